// ===== src/tknrl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tknrl_pkg
// Shared types and constants for the top-k nearest results list.
// ----------------------------------------------------------------------------
package tknrl_pkg;

    localparam int ID_W          = 32;
    localparam int DIST_W        = 16;
    localparam int SIZE_W        = 5;
    localparam int HELD_W        = 5;
    localparam int LIST_SIZE_RST = 16;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_DUMP  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0]   out_id;
        logic [DIST_W-1:0] out_distance;
        logic              out_valid;
        logic              accepted;
        logic [HELD_W-1:0] entries_held;
        logic              last;
    } t_rsp;

endpackage
`default_nettype wire

// ===== src/tknrl_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tknrl interfaces
// Request, response and list-size write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tknrl_req_if import tknrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ID_W-1:0]   result_id;
    logic [DIST_W-1:0] result_distance;

    modport source (output valid, req_type, result_id, result_distance, input ready);
    modport sink   (input valid, req_type, result_id, result_distance, output ready);
endinterface

interface tknrl_rsp_if import tknrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   out_id;
    logic [DIST_W-1:0] out_distance;
    logic              out_valid;
    logic              accepted;
    logic [HELD_W-1:0] entries_held;
    logic              last;

    modport source (output valid, out_id, out_distance, out_valid, accepted,
                    entries_held, last, input ready);
    modport sink   (input valid, out_id, out_distance, out_valid, accepted,
                    entries_held, last, output ready);
endinterface

interface tknrl_cfg_if import tknrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] list_size;

    modport source (output valid, list_size, input ready);
    modport sink   (input valid, list_size, output ready);
endinterface
`default_nettype wire

// ===== src/top_k_nearest_results_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_nearest_results_list
// Keeps the best (smallest distance) results in a sorted list held in one
// synchronous RAM; insertion shifts worse entries up one slot at a time.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat
// i_req    in   req_type, result_id, result_distance
// o_rsp    out  out_id, out_distance, out_valid, accepted, entries_held, last
// i_cfg    in   list_size (always ready)
//
// One request is in work at a time; i_req.ready is high only in idle.
// Add with room left: each worse entry shifts up one slot, then the new
// entry is written and the response loaded. Add to a full list: the worst
// entry is compared first; a rejected result goes straight to the response,
// else it takes the worst slot and worse entries shift up as above. Dump:
// the first entry is read, then one entry beat per cycle once the output register is free.
// Reset empties the list at once; the RAM needs no clearing pass.
// A stalled o_rsp holds the beat in the output register and stalls the list.
// ----------------------------------------------------------------------------
module top_k_nearest_results_list
    import tknrl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tknrl_req_if.sink   i_req,
    tknrl_rsp_if.source o_rsp,
    tknrl_cfg_if.sink   i_cfg
);

    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW_N = $clog2(MAX_ENTRIES + 1);
    localparam int CW   = (CW_N < SIZE_W) ? SIZE_W : CW_N;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FULL_CMP = 7'b0000010,
        S_SH_CMP   = 7'b0000100,
        S_INS      = 7'b0001000,
        S_EMIT     = 7'b0010000,
        S_DUMP_OUT = 7'b0100000,
        S_SPARE    = 7'b1000000
    } t_state;

    function automatic logic [CW-1:0] eff_size(input logic [SIZE_W-1:0] sz);
        logic [CW-1:0] v;
        v = CW'(sz);
        if (v == '0) begin
            return CW'(1);
        end else if (v > CW'(MAX_ENTRIES)) begin
            return CW'(MAX_ENTRIES);
        end
        return v;
    endfunction

    t_entry        mem [MAX_ENTRIES];

    t_state        r_state, n_state;
    logic [CW-1:0] r_held, n_held;
    logic [SIZE_W-1:0] r_size;
    logic [IW-1:0] r_idx, n_idx;
    t_entry        r_cand, n_cand;
    logic          r_acc, n_acc;
    t_entry        r_rdata;
    logic          r_ov, n_ov;
    t_rsp          r_out, n_out;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;

    logic          can_push;
    logic [CW-1:0] w_size;
    logic [CW-1:0] w_cfg_size;
    logic          w_dump_last;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_ov;
    assign o_rsp.out_id       = r_out.out_id;
    assign o_rsp.out_distance = r_out.out_distance;
    assign o_rsp.out_valid    = r_out.out_valid;
    assign o_rsp.accepted     = r_out.accepted;
    assign o_rsp.entries_held = r_out.entries_held;
    assign o_rsp.last         = r_out.last;

    assign can_push    = !r_ov || o_rsp.ready;
    assign w_size      = eff_size(r_size);
    assign w_cfg_size  = eff_size(i_cfg.list_size);
    assign w_dump_last = ((CW'(r_idx) + CW'(1)) == r_held);

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_idx   = r_idx;
        n_cand  = r_cand;
        n_acc   = r_acc;
        n_ov    = r_ov && !o_rsp.ready;
        n_out   = r_out;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_cand;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_acc = 1'b0;
                    case (t_req'(i_req.req_type))
                        REQ_ADD: begin
                            n_cand.id       = i_req.result_id;
                            n_cand.distance = i_req.result_distance;
                            if (r_held < w_size) begin
                                n_held = r_held + CW'(1);
                                n_acc  = 1'b1;
                                n_idx  = IW'(r_held);
                                if (r_held == '0) begin
                                    n_state = S_INS;
                                end else begin
                                    rd_en   = 1'b1;
                                    rd_addr = IW'(r_held - CW'(1));
                                    n_state = S_SH_CMP;
                                end
                            end else begin
                                // full: look at the worst entry first
                                rd_en   = 1'b1;
                                rd_addr = IW'(r_held - CW'(1));
                                n_idx   = IW'(r_held - CW'(1));
                                n_state = S_FULL_CMP;
                            end
                        end
                        REQ_DUMP: begin
                            if (r_held == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_DUMP_OUT;
                            end
                        end
                        REQ_CLEAR: begin
                            n_held  = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_FULL_CMP: begin
                if (r_rdata.distance > r_cand.distance) begin
                    n_acc = 1'b1;
                    if (r_idx == '0) begin
                        wr_en   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - IW'(1);
                        n_state = S_SH_CMP;
                    end
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SH_CMP: begin
                // r_rdata holds the entry just below slot r_idx
                if (r_rdata.distance > r_cand.distance) begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata;
                    n_idx   = r_idx - IW'(1);
                    if (r_idx == IW'(1)) begin
                        n_state = S_INS;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - IW'(2);
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_INS: begin
                wr_en   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (can_push) begin
                    n_ov               = 1'b1;
                    n_out.out_id       = '0;
                    n_out.out_distance = '0;
                    n_out.out_valid    = 1'b0;
                    n_out.accepted     = r_acc;
                    n_out.entries_held = HELD_W'(r_held);
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_DUMP_OUT: begin
                if (can_push) begin
                    n_ov               = 1'b1;
                    n_out.out_id       = r_rdata.id;
                    n_out.out_distance = r_rdata.distance;
                    n_out.out_valid    = 1'b1;
                    n_out.accepted     = 1'b0;
                    n_out.entries_held = HELD_W'(r_held);
                    n_out.last         = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + IW'(1);
                        n_idx   = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // drop the worst entries when the list shrinks
        if (i_cfg.valid && (r_held > w_cfg_size)) begin
            n_held = w_cfg_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_size  <= SIZE_W'(LIST_SIZE_RST);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_ov    <= n_ov;
            if (i_cfg.valid) begin
                r_size <= i_cfg.list_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cand <= n_cand;
        r_acc  <= n_acc;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/tknrl_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tknrl_chk
// Port-level checks on the response channel of the results list.
// ----------------------------------------------------------------------------
module tknrl_chk
    import tknrl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_rsp_valid,
    input wire              i_rsp_ready,
    input wire [ID_W-1:0]   i_out_id,
    input wire [DIST_W-1:0] i_out_distance,
    input wire              i_out_valid,
    input wire              i_accepted,
    input wire [HELD_W-1:0] i_entries_held,
    input wire              i_last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_out_id)
            && $stable(i_out_distance) && $stable(i_last))
        else $error("response beat changed under stall");

    a_entry_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_out_valid |-> !i_accepted)
        else $error("dump beat flagged accepted");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_out_valid |-> i_last && i_out_id == '0
            && i_out_distance == '0)
        else $error("non-entry beat carries payload or is not last");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (MAX_ENTRIES < 32) |-> int'(i_entries_held) <= MAX_ENTRIES)
        else $error("entry count above capacity");

    // a dump with more beats keeps the same count through the burst
    a_burst_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_rsp_valid && i_rsp_ready && i_out_valid && !i_last
            ##1 i_rsp_valid |-> i_out_valid && $stable(i_entries_held))
        else $error("dump burst broken");

endmodule

bind top_k_nearest_results_list tknrl_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_tknrl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_out_id       (o_rsp.out_id),
    .i_out_distance (o_rsp.out_distance),
    .i_out_valid    (o_rsp.out_valid),
    .i_accepted     (o_rsp.accepted),
    .i_entries_held (o_rsp.entries_held),
    .i_last         (o_rsp.last)
);
`default_nettype wire
